@@ rtl/core/pst_pkg.sv @@
// ============================================================================
// pst_pkg
// Shared types and codes for the periodic slot table.
// ============================================================================
package pst_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_MASK = 8'd1;

    localparam logic [2:0] OP_ADD       = 3'd0;
    localparam logic [2:0] OP_REMOVE    = 3'd1;
    localparam logic [2:0] OP_SHIFT_ALL = 3'd2;
    localparam logic [2:0] OP_SHIFT_ONE = 3'd3;
    localparam logic [2:0] OP_SET_FLAGS = 3'd4;
    localparam logic [2:0] OP_CLEAR     = 3'd5;
    localparam logic [2:0] OP_READ      = 3'd6;
    localparam logic [2:0] OP_IGNORED   = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_MANY  = 3'd1;
    localparam logic [2:0] ST_ZERO_STEP = 3'd2;
    localparam logic [2:0] ST_SHIFT_BIG = 3'd3;
    localparam logic [2:0] ST_OCCUPIED  = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_BAD_FLAGS = 3'd6;
    localparam logic [2:0] ST_FULL      = 3'd7;

    typedef struct packed {
        logic [2:0]         operation;
        logic [30:0]        slot_time;
        logic [30:0]        stride;
        logic [9:0]         extra_count;
        logic signed [31:0] adjustment;
        logic [15:0]        flag_values;
        logic [15:0]        flag_mask;
        logic [7:0]         read_index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] result_offset;
        logic [15:0] result_flags;
        logic [8:0]  slot_count;
    } res_t;

endpackage

@@ rtl/core/periodic_slot_table_top.sv @@
// ============================================================================
// periodic_slot_table_top
// Sorted table of offsets in a repeating period with flag words.
// ============================================================================
//  channel | direction | transfer when          | payload
//  s_axis  | in        | tvalid & tready        | tuser op, tdata operands
//  m_axis  | out       | tvalid & tready        | tuser status, tdata result
//  cfg     | in        | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
//  Read fetches one entry; remove, set flags and shift one scan the entries in order;
//  shift one then runs a full insertion sort over the table; add searches and inserts
//  once per offset added; shift all rewrites every entry and then runs the sort.
//  The table is a single memory, with one read and one write per cycle.
//  Reset clears the count; table contents are not cleared (no clearing pass).
//  One result register; the engine waits when it is full and not taken.
// ============================================================================
module periodic_slot_table_top #(
    parameter int MAX_SLOTS = 256,
    parameter int MAX_EXTRA = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // slot_time, stride, extra_count, adjustment, flag_values, flag_mask, read_index
    input  logic [143:0]                  s_axis_tdata,
    // operation
    input  logic [2:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_offset, result_flags, slot_count
    output logic [55:0]                   m_axis_tdata,
    // status
    output logic [2:0]                    m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    logic [30:0]   period_reg;
    logic [15:0]   pmask_reg;
    pst_pkg::cmd_t cmd;
    pst_pkg::res_t res;
    logic          res_valid;
    logic          res_ready;
    logic          m_valid_reg;
    pst_pkg::res_t m_res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= 31'd1;
            pmask_reg  <= 16'hFFFF;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pst_pkg::CFG_PERIOD:    period_reg <= cfg_data[30:0];
                pst_pkg::CFG_FLAG_MASK: pmask_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cmd = '{operation:   s_axis_tuser,
                   slot_time:   s_axis_tdata[30:0],
                   stride:      s_axis_tdata[61:31],
                   extra_count: s_axis_tdata[71:62],
                   adjustment:  s_axis_tdata[103:72],
                   flag_values: s_axis_tdata[119:104],
                   flag_mask:   s_axis_tdata[135:120],
                   read_index:  s_axis_tdata[143:136]};

    pst_engine #(
        .MAX_SLOTS(MAX_SLOTS),
        .MAX_EXTRA(MAX_EXTRA)
    ) u_engine (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd_valid           (s_axis_tvalid),
        .cmd_ready           (s_axis_tready),
        .cmd                 (cmd),
        .period_ticks        (period_reg),
        .permitted_flag_mask (pmask_reg),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .res                 (res)
    );

    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) m_res_reg <= res;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = {m_res_reg.slot_count, m_res_reg.result_flags,
                            m_res_reg.result_offset};

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while engine busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> 32'(m_axis_tdata[55:47]) <= 32'(MAX_SLOTS))
        else $error("slot count above table size");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == pst_pkg::ST_FULL
        |-> 32'(m_axis_tdata[55:47]) == 32'(MAX_SLOTS))
        else $error("full status with room left");

    a_err_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != pst_pkg::ST_OK |-> m_axis_tdata[46:0] == '0)
        else $error("error result carries data");

endmodule

@@ rtl/core/pst_engine.sv @@
// ============================================================================
// pst_engine
// Sequencer over the sorted slot memory: search, insert, remove, shift, sort, read, set flags, clear.
// ============================================================================
module pst_engine #(
    parameter int MAX_SLOTS = 256,
    parameter int MAX_EXTRA = 512
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  pst_pkg::cmd_t cmd,
    input  logic [30:0]   period_ticks,
    input  logic [15:0]   permitted_flag_mask,
    output logic          res_valid,
    input  logic          res_ready,
    output pst_pkg::res_t res
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_FIND_RD   = 5'd1;
    localparam logic [4:0] S_FIND_CMP  = 5'd2;
    localparam logic [4:0] S_MV_RD     = 5'd3;
    localparam logic [4:0] S_MV_WR     = 5'd4;
    localparam logic [4:0] S_SH_A      = 5'd5;
    localparam logic [4:0] S_SH_B      = 5'd6;
    localparam logic [4:0] S_SA_RD     = 5'd7;
    localparam logic [4:0] S_SA_A      = 5'd8;
    localparam logic [4:0] S_SA_B      = 5'd9;
    localparam logic [4:0] S_SO_I      = 5'd10;
    localparam logic [4:0] S_SO_H      = 5'd11;
    localparam logic [4:0] S_SO_J      = 5'd12;
    localparam logic [4:0] S_SO_C      = 5'd13;
    localparam logic [4:0] S_INS_RD    = 5'd14;
    localparam logic [4:0] S_INS_CMP   = 5'd15;
    localparam logic [4:0] S_INS_PLACE = 5'd16;
    localparam logic [4:0] S_INS_SH    = 5'd17;
    localparam logic [4:0] S_INS_SW    = 5'd18;
    localparam logic [4:0] S_INS_NEXT  = 5'd19;
    localparam logic [4:0] S_INS_WRAP  = 5'd20;
    localparam logic [4:0] S_RD_WAIT   = 5'd21;
    localparam logic [4:0] S_DONE      = 5'd22;

    typedef struct packed {
        logic [30:0] off;
        logic [15:0] flags;
    } entry_t;

    entry_t        mem [MAX_SLOTS];
    entry_t        rdata_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    logic [4:0]    state_reg, state_next;
    pst_pkg::cmd_t cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [9:0]    rem_reg, rem_next;
    logic [30:0]   key_reg, key_next;
    logic [30:0]   nw_reg, nw_next;
    entry_t        hold_reg, hold_next;
    logic [32:0]   t_reg, t_next;
    logic          phase_reg, phase_next;
    logic          dropped_reg, dropped_next;
    logic [2:0]    status_reg, status_next;
    logic [30:0]   roff_reg, roff_next;
    logic [15:0]   rflags_reg, rflags_next;

    logic [31:0]   mag;
    logic          full;
    logic          greater;

    function automatic logic [32:0] shift_lo(input logic [30:0] off,
                                             input logic [31:0] adj,
                                             input logic [30:0] p);
        logic [32:0] s;
        s = {2'b00, off} + {adj[31], adj};
        if (s[32]) s = s + {2'b00, p};
        return s;
    endfunction

    function automatic logic [30:0] wrap_hi(input logic [32:0] t,
                                            input logic [30:0] p);
        logic [31:0] d;
        d = t[31:0] - {1'b0, p};
        if (!t[32] && (t[31:0] >= {1'b0, p})) return d[30:0];
        return t[30:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rdata_reg <= mem[rd_addr];
    end

    assign mag       = cmd.adjustment[31] ? (~cmd.adjustment + 32'd1) : cmd.adjustment;
    assign full      = (count_reg == CW'(MAX_SLOTS));
    assign greater   = (rdata_reg.off > hold_reg.off) ||
                       ((rdata_reg.off == hold_reg.off) && (rdata_reg.flags > hold_reg.flags));
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{status: status_reg, result_offset: roff_reg,
                         result_flags: rflags_reg, slot_count: 9'(count_reg)};

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        rem_next     = rem_reg;
        key_next     = key_reg;
        nw_next      = nw_reg;
        hold_next    = hold_reg;
        t_next       = t_reg;
        phase_next   = phase_reg;
        dropped_next = dropped_reg;
        status_next  = status_reg;
        roff_next    = roff_reg;
        rflags_next  = rflags_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next    = cmd;
                    status_next = pst_pkg::ST_OK;
                    roff_next   = '0;
                    rflags_next = '0;
                    i_next      = '0;
                    phase_next  = 1'b0;
                    key_next    = cmd.slot_time;
                    state_next  = S_DONE;
                    unique case (cmd.operation) inside
                        pst_pkg::OP_ADD: begin
                            if (32'(cmd.extra_count) > 32'(MAX_EXTRA)) begin
                                status_next = pst_pkg::ST_TOO_MANY;
                            end else if (cmd.extra_count != '0 && cmd.stride == '0) begin
                                status_next = pst_pkg::ST_ZERO_STEP;
                            end else begin
                                rem_next     = cmd.extra_count;
                                dropped_next = 1'b0;
                                state_next   = S_INS_RD;
                            end
                        end
                        pst_pkg::OP_REMOVE: state_next = S_FIND_RD;
                        pst_pkg::OP_SHIFT_ALL, pst_pkg::OP_SHIFT_ONE: begin
                            if (mag >= {1'b0, period_ticks}) begin
                                status_next = pst_pkg::ST_SHIFT_BIG;
                            end else if (cmd.operation == pst_pkg::OP_SHIFT_ALL) begin
                                state_next = S_SA_RD;
                            end else begin
                                state_next = S_SH_A;
                            end
                        end
                        pst_pkg::OP_SET_FLAGS: begin
                            if ((cmd.flag_mask & ~permitted_flag_mask) != '0 ||
                                (cmd.flag_values & ~cmd.flag_mask) != '0) begin
                                status_next = pst_pkg::ST_BAD_FLAGS;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        pst_pkg::OP_CLEAR: count_next = '0;
                        pst_pkg::OP_READ: begin
                            if (32'(cmd.read_index) >= 32'(count_reg)) begin
                                status_next = pst_pkg::ST_NOT_FOUND;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(cmd.read_index);
                                state_next = S_RD_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT: begin
                roff_next   = rdata_reg.off;
                rflags_next = rdata_reg.flags;
                state_next  = S_DONE;
            end
            S_FIND_RD: begin
                if (i_reg == count_reg) begin
                    state_next = S_DONE;
                    if (cmd_reg.operation == pst_pkg::OP_SET_FLAGS) begin
                        status_next = pst_pkg::ST_NOT_FOUND;
                    end else if (cmd_reg.operation == pst_pkg::OP_SHIFT_ONE) begin
                        if (!phase_reg) begin
                            phase_next = 1'b1;
                            key_next   = cmd_reg.slot_time;
                            i_next     = '0;
                            state_next = S_FIND_RD;
                        end else begin
                            status_next = pst_pkg::ST_NOT_FOUND;
                        end
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[AW-1:0];
                    state_next = S_FIND_CMP;
                end
            end
            S_FIND_CMP: begin
                if (rdata_reg.off == key_reg) begin
                    state_next = S_DONE;
                    if (cmd_reg.operation == pst_pkg::OP_REMOVE) begin
                        state_next = S_MV_RD;
                    end else if (cmd_reg.operation == pst_pkg::OP_SET_FLAGS) begin
                        wr_en   = 1'b1;
                        wr_addr = i_reg[AW-1:0];
                        wr_data = '{off: rdata_reg.off,
                                    flags: (rdata_reg.flags & ~cmd_reg.flag_mask)
                                           | cmd_reg.flag_values};
                    end else if (!phase_reg) begin
                        status_next = pst_pkg::ST_OCCUPIED;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = i_reg[AW-1:0];
                        wr_data    = '{off: nw_reg, flags: rdata_reg.flags};
                        i_next     = CW'(1);
                        state_next = S_SO_I;
                    end
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_MV_RD: begin
                if (i_reg + CW'(1) == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(i_reg + CW'(1));
                    state_next = S_MV_WR;
                end
            end
            S_MV_WR: begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[AW-1:0];
                wr_data    = rdata_reg;
                i_next     = i_reg + CW'(1);
                state_next = S_MV_RD;
            end
            S_SH_A: begin
                t_next     = shift_lo(cmd_reg.slot_time, cmd_reg.adjustment, period_ticks);
                state_next = S_SH_B;
            end
            S_SH_B: begin
                nw_next    = wrap_hi(t_reg, period_ticks);
                key_next   = wrap_hi(t_reg, period_ticks);
                i_next     = '0;
                state_next = S_FIND_RD;
            end
            S_SA_RD: begin
                if (i_reg == count_reg) begin
                    i_next     = CW'(1);
                    state_next = S_SO_I;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[AW-1:0];
                    state_next = S_SA_A;
                end
            end
            S_SA_A: begin
                t_next     = shift_lo(rdata_reg.off, cmd_reg.adjustment, period_ticks);
                hold_next  = rdata_reg;
                state_next = S_SA_B;
            end
            S_SA_B: begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[AW-1:0];
                wr_data    = '{off: wrap_hi(t_reg, period_ticks), flags: hold_reg.flags};
                i_next     = i_reg + CW'(1);
                state_next = S_SA_RD;
            end
            S_SO_I: begin
                if (i_reg >= count_reg) begin
                    if (cmd_reg.operation == pst_pkg::OP_SHIFT_ONE) roff_next = nw_reg;
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[AW-1:0];
                    state_next = S_SO_H;
                end
            end
            S_SO_H: begin
                hold_next  = rdata_reg;
                j_next     = i_reg;
                state_next = S_SO_J;
            end
            S_SO_J: begin
                if (j_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = hold_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SO_I;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(j_reg - CW'(1));
                    state_next = S_SO_C;
                end
            end
            S_SO_C: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                if (greater) begin
                    wr_data    = rdata_reg;
                    j_next     = j_reg - CW'(1);
                    state_next = S_SO_J;
                end else begin
                    wr_data    = hold_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SO_I;
                end
            end
            S_INS_RD: begin
                if (i_reg == count_reg) begin
                    state_next = S_INS_PLACE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[AW-1:0];
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (rdata_reg.off < key_reg) begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_INS_RD;
                end else if (rdata_reg.off == key_reg) begin
                    state_next = S_INS_NEXT;
                end else begin
                    state_next = S_INS_PLACE;
                end
            end
            S_INS_PLACE: begin
                if (full) begin
                    dropped_next = 1'b1;
                    state_next   = S_INS_NEXT;
                end else begin
                    j_next     = count_reg;
                    k_next     = i_reg;
                    state_next = S_INS_SH;
                end
            end
            S_INS_SH: begin
                if (j_reg == k_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = k_reg[AW-1:0];
                    wr_data    = '{off: key_reg, flags: '0};
                    count_next = count_reg + CW'(1);
                    state_next = S_INS_NEXT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(j_reg - CW'(1));
                    state_next = S_INS_SW;
                end
            end
            S_INS_SW: begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                wr_data    = rdata_reg;
                j_next     = j_reg - CW'(1);
                state_next = S_INS_SH;
            end
            S_INS_NEXT: begin
                if (rem_reg == '0) begin
                    status_next = dropped_reg ? pst_pkg::ST_FULL : pst_pkg::ST_OK;
                    state_next  = S_DONE;
                end else begin
                    rem_next   = rem_reg - 10'd1;
                    t_next     = {2'b00, key_reg} + {2'b00, cmd_reg.stride};
                    state_next = S_INS_WRAP;
                end
            end
            S_INS_WRAP: begin
                key_next   = wrap_hi(t_reg, period_ticks);
                i_next     = '0;
                state_next = S_INS_RD;
            end
            S_DONE: begin
                if (res_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        cmd_reg     <= cmd_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        rem_reg     <= rem_next;
        key_reg     <= key_next;
        nw_reg      <= nw_next;
        hold_reg    <= hold_next;
        t_reg       <= t_next;
        phase_reg   <= phase_next;
        dropped_reg <= dropped_next;
        status_reg  <= status_next;
        roff_reg    <= roff_next;
        rflags_reg  <= rflags_next;
    end

endmodule
